// ===== sv/mhpq_pkg.sv =====
package mhpq_pkg;

  // default number of keys the heap holds
  localparam int unsigned MHPQ_CAPACITY = 256;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 2;

  // opcodes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                    opcode;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] result_key;
    logic [STATUS_W-1:0]     status;
  } res_t;

  // kind of work a token carries down the row of level cells
  typedef enum logic [1:0] {
    TOK_INS  = 2'b01,
    TOK_SIFT = 2'b10
  } tok_op_e;

endpackage

// ===== sv/max_heap_priority_queue_core.sv =====
// max-heap priority queue of signed 32-bit keys
// command channel: cmd_i (opcode, key) is taken at a clock edge where start
// is high and busy is low. opcode insert adds the key, opcode extract removes
// and returns the largest key held.
// result channel: every item gives exactly one result on res_o, shown for a
// single cycle with res_valid_o high. the receiver cannot hold results off.
// status is ok, empty (extract with nothing held, key zero) or full (insert
// dropped, key zero). result_key is zero on every insert.
// the heap is kept as a row of level cells, one per tree level, each with a
// small memory of its level's nodes; a token walks the row one level at a
// time. at each level above where its walk ends, a cell does a registered
// memory read, then the compare, the write back and the handoff to the next
// cell. an insert walks from the root to the new slot's level; an extract
// reads the root and the last node, then sifts the moved key down until it
// settles. full and empty items answer in the next cycle and never raise
// busy. one item at a time: otherwise busy stays high until the result
// shows, and the next item may be taken in that same cycle.
// reset clears the count and all control state; node memories are not
// cleared and no wait follows reset.
module max_heap_priority_queue_core
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = MHPQ_CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned LEVELS = $clog2(CAPACITY + 1);
  localparam int unsigned CNT_W  = LEVELS;
  localparam int unsigned OFF_W  = LEVELS - 1;
  localparam int unsigned LVL_W  = $clog2(LEVELS);

  // token handed from cell to cell
  typedef struct packed {
    logic                    valid;
    tok_op_e                 op;
    logic signed [KEY_W-1:0] key;
    logic [OFF_W-1:0]        off;   // node offset within the current level
    logic [CNT_W-1:0]        tgt;   // 1-based index of the new slot (insert)
    logic [LVL_W-1:0]        lvl;   // level of the new slot (insert)
    logic [CNT_W-1:0]        cnt;   // keys held after this item
  } tok_t;

  // child-row read that a cell asks of the cell below
  typedef struct packed {
    logic             en;
    logic [OFF_W-1:0] row;
  } crd_t;

  // read of the root and the last node at the start of an extract
  typedef struct packed {
    logic             en;
    logic [LVL_W-1:0] lvl;
    logic [OFF_W-1:0] off;
  } peek_t;

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_PEEK  = 4'b0010,
    T_PWAIT = 4'b0100,
    T_RUN   = 4'b1000
  } tstate_e;

  tstate_e st_q, st_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  tok_t             tok0_q, tok0_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;
  logic [LVL_W-1:0] peek_lvl_q, peek_lvl_d;
  logic [OFF_W-1:0] peek_off_q, peek_off_d;

  tok_t               tok   [LEVELS+1];
  crd_t               crd   [LEVELS+1];
  logic [2*KEY_W-1:0] rdata [LEVELS+1];
  logic [LEVELS-1:0]  done;
  peek_t              peek;

  logic                    accept;
  logic [CNT_W-1:0]        enc_n, enc_off_full;
  logic [LVL_W-1:0]        enc_lvl;
  logic [2*KEY_W-1:0]      last_row;
  logic signed [KEY_W-1:0] last_key;

  assign accept      = start && !busy;
  assign busy        = (st_q != T_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign tok[0]        = tok0_q;
  assign crd[0]        = '0;
  assign rdata[LEVELS] = '0;

  assign peek.en  = (st_q == T_PEEK);
  assign peek.lvl = peek_lvl_q;
  assign peek.off = peek_off_q;

  // level and in-level offset of the slot an item works on: the new slot
  // for an insert, the last filled slot for an extract
  always_comb begin
    enc_n   = (cmd_i.opcode == OP_INSERT) ? (cnt_q + CNT_W'(1)) : cnt_q;
    enc_lvl = '0;
    for (int k = 0; k < CNT_W; k++) begin
      if (enc_n[k]) begin
        enc_lvl = LVL_W'(k);
      end
    end
    enc_off_full          = enc_n;
    enc_off_full[enc_lvl] = 1'b0;
  end

  // the last node, read back from the cell of its level
  always_comb begin
    last_row = '0;
    for (int k = 0; k < LEVELS; k++) begin
      if (peek_lvl_q == LVL_W'(k)) begin
        last_row = rdata[k];
      end
    end
    last_key = peek_off_q[0] ? $signed(last_row[2*KEY_W-1:KEY_W])
                             : $signed(last_row[KEY_W-1:0]);
  end

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    tok0_d      = tok0_q;
    tok0_d.valid = 1'b0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    peek_lvl_d  = peek_lvl_q;
    peek_off_d  = peek_off_q;
    unique case (st_q)
      T_IDLE: begin
        if (accept) begin
          res_d.result_key = '0;
          res_d.status     = ST_OK;
          if (cmd_i.opcode == OP_INSERT) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              res_d.status = ST_FULL;
              res_valid_d  = 1'b1;
            end else begin
              // walk from the root to the new slot
              tok0_d.valid = 1'b1;
              tok0_d.op    = TOK_INS;
              tok0_d.key   = cmd_i.key;
              tok0_d.off   = '0;
              tok0_d.tgt   = enc_n;
              tok0_d.lvl   = enc_lvl;
              tok0_d.cnt   = enc_n;
              cnt_d        = enc_n;
              st_d         = T_RUN;
            end
          end else begin
            if (cnt_q == '0) begin
              res_d.status = ST_EMPTY;
              res_valid_d  = 1'b1;
            end else begin
              peek_lvl_d = enc_lvl;
              peek_off_d = enc_off_full[OFF_W-1:0];
              cnt_d      = cnt_q - CNT_W'(1);
              st_d       = T_PEEK;
            end
          end
        end
      end
      T_PEEK: begin
        st_d = T_PWAIT;
      end
      T_PWAIT: begin
        // root goes out, last node restarts at the root
        res_d.result_key = $signed(rdata[0][KEY_W-1:0]);
        if (cnt_q == '0) begin
          res_valid_d = 1'b1;
          st_d        = T_IDLE;
        end else begin
          tok0_d.valid = 1'b1;
          tok0_d.op    = TOK_SIFT;
          tok0_d.key   = last_key;
          tok0_d.off   = '0;
          tok0_d.tgt   = cnt_q;
          tok0_d.lvl   = '0;
          tok0_d.cnt   = cnt_q;
          st_d         = T_RUN;
        end
      end
      T_RUN: begin
        if (|done) begin
          res_valid_d = 1'b1;
          st_d        = T_IDLE;
        end
      end
      default: st_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= T_IDLE;
      cnt_q       <= '0;
      tok0_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      tok0_q      <= tok0_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    peek_lvl_q <= peek_lvl_d;
    peek_off_q <= peek_off_d;
  end

  // one cell per tree level
  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    mhpq_cell #(
      .CAPACITY (CAPACITY),
      .LEVEL    (k),
      .tok_t    (tok_t),
      .crd_t    (crd_t),
      .peek_t   (peek_t)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok[k]),
      .tok_o   (tok[k+1]),
      .crd_i   (crd[k]),
      .crd_o   (crd[k+1]),
      .peek_i  (peek),
      .rdata_o (rdata[k]),
      .cdata_i (rdata[k+1]),
      .done_o  (done[k])
    );
  end

endmodule

// ===== sv/mhpq_cell.sv =====
module mhpq_cell
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = MHPQ_CAPACITY,
  parameter int unsigned LEVEL    = 0,
  parameter type         tok_t    = logic,
  parameter type         crd_t    = logic,
  parameter type         peek_t   = logic
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tok_t               tok_i,
  output tok_t               tok_o,
  input  crd_t               crd_i,
  output crd_t               crd_o,
  input  peek_t              peek_i,
  output logic [2*KEY_W-1:0] rdata_o,
  input  logic [2*KEY_W-1:0] cdata_i,
  output logic               done_o
);

  localparam int unsigned LEVELS   = $clog2(CAPACITY + 1);
  localparam int unsigned CNT_W    = LEVELS;
  localparam int unsigned OFF_W    = LEVELS - 1;
  localparam int unsigned LVL_W    = $clog2(LEVELS);
  localparam int unsigned FIRST    = (1 << LEVEL) - 1;
  localparam int unsigned NODES    = ((CAPACITY - FIRST) < (1 << LEVEL)) ?
                                     (CAPACITY - FIRST) : (1 << LEVEL);
  localparam int unsigned ROWS     = (NODES + 1) / 2;
  localparam int unsigned MEM_ROWS = (ROWS < 2) ? 2 : ROWS;
  localparam int unsigned ROW_AW   = $clog2(MEM_ROWS);
  localparam logic [CNT_W:0]   NODE_BASE = (CNT_W + 1)'(1 << LEVEL);
  localparam logic [LVL_W-1:0] MY_LVL    = LVL_W'(LEVEL);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_ACT  = 3'b010,
    C_WAIT = 3'b100
  } cstate_e;

  cstate_e st_q, st_d;
  tok_t    cur_q, cur_d;

  // one row holds two sibling nodes, slot 0 in the low half
  logic [2*KEY_W-1:0] mem_q [MEM_ROWS];
  logic [2*KEY_W-1:0] rdata_q;

  logic              rd_en, own_rd;
  logic [ROW_AW-1:0] rd_row, node_row;
  logic              wr_en;
  logic signed [KEY_W-1:0] wr_key, carry, own_val, left, right, best_l;
  logic [OFF_W-1:0]  cur_half, peek_half;
  logic              at_tgt, lv, rv, take_l, take_r;
  logic [CNT_W+1:0]  lidx, cnt_ext;
  logic [LVL_W-1:0]  bidx;

  assign rdata_o  = rdata_q;
  assign cur_half = cur_q.off >> 1;
  assign node_row = cur_half[ROW_AW-1:0];
  assign at_tgt   = (cur_q.lvl == MY_LVL);
  assign bidx     = cur_q.lvl - MY_LVL - LVL_W'(1);

  // children of this node exist while their 1-based index stays within the count
  assign lidx    = {NODE_BASE + (CNT_W + 1)'(cur_q.off), 1'b0};
  assign cnt_ext = (CNT_W + 2)'(cur_q.cnt);
  assign lv      = (lidx <= cnt_ext);
  assign rv      = (lidx < cnt_ext);

  assign own_val = cur_q.off[0] ? $signed(rdata_q[2*KEY_W-1:KEY_W])
                                : $signed(rdata_q[KEY_W-1:0]);
  assign left    = $signed(cdata_i[KEY_W-1:0]);
  assign right   = $signed(cdata_i[2*KEY_W-1:KEY_W]);
  assign take_l  = (left > cur_q.key);
  assign best_l  = take_l ? left : cur_q.key;
  assign take_r  = rv && (right > best_l);

  assign peek_half = (LEVEL == 0) ? '0 : (peek_i.off >> 1);

  always_comb begin
    rd_en  = 1'b0;
    rd_row = node_row;
    if (crd_i.en) begin
      rd_en  = 1'b1;
      rd_row = crd_i.row[ROW_AW-1:0];
    end else if (peek_i.en && ((peek_i.lvl == MY_LVL) || (LEVEL == 0))) begin
      rd_en  = 1'b1;
      rd_row = peek_half[ROW_AW-1:0];
    end else if (own_rd) begin
      rd_en  = 1'b1;
    end
  end

  always_comb begin
    st_d      = st_q;
    cur_d     = cur_q;
    tok_o     = cur_q;
    tok_o.valid = 1'b0;
    crd_o     = '0;
    done_o    = 1'b0;
    own_rd    = 1'b0;
    wr_en     = 1'b0;
    wr_key    = cur_q.key;
    carry     = cur_q.key;
    unique case (st_q)
      C_IDLE: begin
        if (tok_i.valid) begin
          cur_d = tok_i;
          st_d  = C_ACT;
        end
      end
      C_ACT: begin
        if (cur_q.op == TOK_INS) begin
          if (at_tgt) begin
            wr_en  = 1'b1;
            done_o = 1'b1;
            st_d   = C_IDLE;
          end else begin
            own_rd = 1'b1;
            st_d   = C_WAIT;
          end
        end else begin
          if (!lv) begin
            wr_en  = 1'b1;
            done_o = 1'b1;
            st_d   = C_IDLE;
          end else begin
            crd_o.en  = 1'b1;
            crd_o.row = cur_q.off;
            st_d      = C_WAIT;
          end
        end
      end
      C_WAIT: begin
        st_d = C_IDLE;
        if (cur_q.op == TOK_INS) begin
          // larger key stays on the path, the smaller one moves down
          if (cur_q.key > own_val) begin
            wr_en = 1'b1;
            carry = own_val;
          end
          tok_o.valid = 1'b1;
          tok_o.key   = carry;
          tok_o.off   = OFF_W'({cur_q.off, cur_q.tgt[bidx]});
        end else begin
          wr_en = 1'b1;
          if (take_r) begin
            wr_key      = right;
            tok_o.valid = 1'b1;
            tok_o.off   = OFF_W'({cur_q.off, 1'b1});
          end else if (take_l) begin
            wr_key      = left;
            tok_o.valid = 1'b1;
            tok_o.off   = OFF_W'({cur_q.off, 1'b0});
          end else begin
            done_o = 1'b1;
          end
        end
      end
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= C_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (wr_en) begin
      if (cur_q.off[0]) begin
        mem_q[node_row][2*KEY_W-1:KEY_W] <= wr_key;
      end else begin
        mem_q[node_row][KEY_W-1:0] <= wr_key;
      end
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_row];
    end
  end

endmodule

// ===== sv/mhpq_checker.sv =====
module mhpq_checker
  import mhpq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input cmd_t cmd_i,
  input logic res_valid_o,
  input res_t res_o
);

  // an accepted item either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> res_valid_o || busy)
    else $error("accepted item neither answered nor busy");

  // the block leaves busy only together with its result
  a_busy_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("busy dropped without a result");

  // every result belongs to an accepted item
  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy) || $fell(busy))
    else $error("result without an accepted item");

  // failed items carry a zero key
  a_fail_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == ST_EMPTY || res_o.status == ST_FULL)
      |-> res_o.result_key == '0)
    else $error("failed item with nonzero key");

endmodule

bind max_heap_priority_queue_core mhpq_checker u_mhpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .cmd_i       (cmd_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// ===== tb/tb_max_heap_priority_queue_core.sv =====
module tb_max_heap_priority_queue_core;
  import mhpq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP        = MHPQ_CAPACITY;
  localparam int unsigned N_DIR      = 25;
  localparam int unsigned N_RANDOM   = 1600;
  localparam int unsigned DRAIN_WAIT = 40;
  localparam int unsigned CYCLE_MAX  = 500000;

  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  // one row of the directed table: the item and, where obvious, its result
  typedef struct packed {
    cmd_t cmd;
    logic typed;
    res_t want;
  } stim_row_t;

  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } phase_kind_e;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_i;
  logic res_valid_o;
  res_t res_o;

  // shadow heap kept by the predictor
  logic signed [KEY_W-1:0] heap_keys [CAP];
  int unsigned             heap_count;

  // results owed by the block, oldest first
  res_t        owed_res_q [$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  stim_row_t   dir_rows [N_DIR];

  max_heap_priority_queue_core #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // apply one item to the shadow heap and return the result it gives
  function automatic res_t heap_apply(cmd_t c);
    res_t                    r;
    int unsigned             pos;
    int unsigned             up;
    int unsigned             lc;
    int unsigned             rc;
    int unsigned             big;
    logic signed [KEY_W-1:0] tmp;
    bit                      settled;
    r.result_key = '0;
    r.status     = ST_OK;
    if (c.opcode == OP_INSERT) begin
      if (heap_count >= CAP) begin
        // dropped, heap untouched
        r.status = ST_FULL;
      end else begin
        pos = heap_count;
        heap_keys[pos] = c.key;
        heap_count++;
        // sift up while strictly greater than the parent
        settled = 1'b0;
        while (pos > 0 && !settled) begin
          up = (pos - 1) / 2;
          if (heap_keys[pos] > heap_keys[up]) begin
            tmp            = heap_keys[pos];
            heap_keys[pos] = heap_keys[up];
            heap_keys[up]  = tmp;
            pos            = up;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end else if (heap_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.result_key = heap_keys[0];
      heap_count--;
      heap_keys[0] = heap_keys[heap_count];
      // sift down toward the larger child, left child wins a tie
      pos     = 0;
      settled = 1'b0;
      while (!settled) begin
        lc  = 2 * pos + 1;
        rc  = 2 * pos + 2;
        big = pos;
        if (lc < heap_count && heap_keys[lc] > heap_keys[big]) big = lc;
        if (rc < heap_count && heap_keys[rc] > heap_keys[big]) big = rc;
        if (big == pos) begin
          settled = 1'b1;
        end else begin
          tmp            = heap_keys[pos];
          heap_keys[pos] = heap_keys[big];
          heap_keys[big] = tmp;
          pos            = big;
        end
      end
    end
    return r;
  endfunction

  function automatic stim_row_t drow(logic op, logic signed [KEY_W-1:0] key, logic typed,
                                     logic signed [KEY_W-1:0] rk, logic [STATUS_W-1:0] st);
    stim_row_t s;
    s.cmd.opcode     = op;
    s.cmd.key        = key;
    s.typed          = typed;
    s.want.result_key = rk;
    s.want.status    = st;
    return s;
  endfunction

  // mix of wide random keys, small keys for ties, and the extremes
  function automatic logic signed [KEY_W-1:0] rand_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 9)) inside
      [0:4]: k = $urandom;
      [5:7]: k = $signed($urandom_range(0, 16)) - 8;
      8: begin
        case ($urandom_range(0, 3))
          0:       k = KEY_MAX;
          1:       k = KEY_MIN;
          2:       k = '0;
          default: k = '1;
        endcase
      end
      default: k = $urandom_range(0, 1) ? KEY_MAX - $urandom_range(0, 3)
                                         : KEY_MIN + $urandom_range(0, 3);
    endcase
    return k;
  endfunction

  // mostly back to back or short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit idle_on);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // present one item, hold it until taken, then record what it should give
  task automatic send_item(cmd_t c, logic typed, res_t want, int unsigned gap);
    res_t pred;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    // taken at the first edge where busy was low
    do @(posedge clk_i); while (busy);
    // predictor always runs so its heap tracks the block
    pred = heap_apply(c);
    owed_res_q.push_back(typed ? want : pred);
  endtask

  task automatic send_rand(logic op, bit idle_on);
    cmd_t c;
    c.opcode = op;
    c.key    = rand_key();
    send_item(c, 1'b0, '0, pick_gap(idle_on));
  endtask

  // result checker: every strobe must match the oldest owed result
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (owed_res_q.size() == 0) begin
        mismatch_cnt++;
        $display("%t unexpected result: key %0d status %0d", $time,
                 res_o.result_key, res_o.status);
      end else begin
        want = owed_res_q.pop_front();
        if (res_o.result_key !== want.result_key) begin
          mismatch_cnt++;
          $display("%t result_key mismatch: expected %0d actual %0d", $time,
                   want.result_key, res_o.result_key);
        end
        if (res_o.status !== want.status) begin
          mismatch_cnt++;
          $display("%t status mismatch: expected %0d actual %0d", $time,
                   want.status, res_o.status);
        end
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_MAX) begin
      $display("tb_max_heap_priority_queue_core failed");
      $finish;
    end
  end

  initial begin
    int unsigned items_sent;
    int unsigned phase_idx;
    int unsigned run_len;
    int unsigned p_ins;
    bit          idle_on;
    phase_kind_e kind;

    rst_ni       <= 1'b0;
    start        <= 1'b0;
    cmd_i        <= '0;
    heap_count   = 0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;

    dir_rows = '{
      // extract right after reset finds nothing
      drow(OP_EXTRACT, 32'sh0000_1234, 1'b1, '0, ST_EMPTY),
      // both key extremes go in and come out in order
      drow(OP_INSERT,  KEY_MAX,        1'b1, '0, ST_OK),
      drow(OP_INSERT,  KEY_MIN,        1'b1, '0, ST_OK),
      drow(OP_EXTRACT, '1,             1'b1, KEY_MAX, ST_OK),
      drow(OP_EXTRACT, '0,             1'b1, KEY_MIN, ST_OK),
      drow(OP_EXTRACT, KEY_MAX,        1'b1, '0, ST_EMPTY),
      // duplicates and signs around zero exercise ties on both sifts
      drow(OP_INSERT,  32'sd5,         1'b0, '0, ST_OK),
      drow(OP_INSERT,  32'sd5,         1'b0, '0, ST_OK),
      drow(OP_INSERT,  -32'sd1,        1'b0, '0, ST_OK),
      drow(OP_INSERT,  32'sd1,         1'b0, '0, ST_OK),
      drow(OP_INSERT,  32'sd0,         1'b0, '0, ST_OK),
      drow(OP_INSERT,  32'sd7,         1'b0, '0, ST_OK),
      drow(OP_INSERT,  32'sd5,         1'b0, '0, ST_OK),
      drow(OP_INSERT,  -32'sd7,        1'b0, '0, ST_OK),
      drow(OP_EXTRACT, 32'sd3,         1'b0, '0, ST_OK),
      drow(OP_EXTRACT, '0,             1'b0, '0, ST_OK),
      drow(OP_EXTRACT, '0,             1'b0, '0, ST_OK),
      drow(OP_EXTRACT, '0,             1'b0, '0, ST_OK),
      drow(OP_EXTRACT, '0,             1'b0, '0, ST_OK),
      drow(OP_EXTRACT, '0,             1'b0, '0, ST_OK),
      drow(OP_EXTRACT, '0,             1'b0, '0, ST_OK),
      drow(OP_EXTRACT, '0,             1'b0, '0, ST_OK),
      drow(OP_EXTRACT, KEY_MIN,        1'b1, '0, ST_EMPTY),
      // alternating bit patterns left in the heap for the random part
      drow(OP_INSERT,  32'shAAAA_AAAA, 1'b0, '0, ST_OK),
      drow(OP_INSERT,  32'sh5555_5555, 1'b0, '0, ST_OK)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, back to back except a few gaps
    for (int i = 0; i < N_DIR; i++) begin
      send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want,
                (i % 4 == 3) ? $urandom_range(1, 5) : 0);
    end

    // random phases: fill to full and past it, drain to empty and past it,
    // and mixed runs at several insert rates
    items_sent = 0;
    phase_idx  = 0;
    while (items_sent < N_RANDOM) begin
      if (phase_idx == 0) kind = PH_FILL;
      else if (phase_idx == 1) kind = PH_DRAIN;
      else begin
        case ($urandom_range(0, 7))
          0:       kind = PH_FILL;
          1:       kind = PH_DRAIN;
          default: kind = PH_MIX;
        endcase
      end
      // some phases run with no idling at all
      idle_on = ($urandom_range(0, 3) != 0);

      case (kind)
        PH_FILL: begin
          while (heap_count < CAP) begin
            send_rand(OP_INSERT, idle_on);
            items_sent++;
          end
          // inserts on a full heap are dropped
          run_len = $urandom_range(1, 4);
          repeat (run_len) begin
            send_rand(OP_INSERT, idle_on);
            items_sent++;
          end
          // hold off until the block has answered everything
          start <= 1'b0;
          while (owed_res_q.size() != 0) @(posedge clk_i);
        end
        PH_DRAIN: begin
          while (heap_count > 0) begin
            send_rand(OP_EXTRACT, idle_on);
            items_sent++;
          end
          // extracts on an empty heap
          run_len = $urandom_range(1, 3);
          repeat (run_len) begin
            send_rand(OP_EXTRACT, idle_on);
            items_sent++;
          end
        end
        default: begin
          run_len = $urandom_range(20, 150);
          case ($urandom_range(0, 2))
            0:       p_ins = 30;
            1:       p_ins = 50;
            default: p_ins = 70;
          endcase
          repeat (run_len) begin
            send_rand(($urandom_range(0, 99) < p_ins) ? OP_INSERT : OP_EXTRACT, idle_on);
            items_sent++;
          end
        end
      endcase
      phase_idx++;
    end

    // let every owed result arrive, then watch a while for strays
    start <= 1'b0;
    while (owed_res_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("tb_max_heap_priority_queue_core passed");
    end else begin
      $display("tb_max_heap_priority_queue_core failed");
    end
    $finish;
  end

endmodule

// ===== max_heap_priority_queue_core.f =====
sv/mhpq_pkg.sv
sv/mhpq_cell.sv
sv/max_heap_priority_queue_core.sv
sv/mhpq_checker.sv
tb/tb_max_heap_priority_queue_core.sv
